// ===== design/giou_pkg.sv =====
// Package for the greedy IoU track assigner: widths, command codes, types.
// No dependencies.
`timescale 1ns / 1ps
package giou_pkg;
  localparam int MaxTracksDef = 8;
  localparam int CoordBitsDef = 12;
  localparam int ThrW = 4;
  localparam logic [ThrW-1:0] ThrReset = 4'd3;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_MATCH = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  typedef struct packed {
    logic        matched;
    logic [7:0]  matched_id;
    logic [2:0]  matched_slot;
    logic        table_full;
  } result_t;
endpackage

// ===== design/giou_if.sv =====
// Valid/ready channel interfaces for the request and result payloads.
// Depends on nothing.
`timescale 1ns / 1ps
interface giou_req_if #(parameter int CB = 12);
  logic valid;
  logic ready;
  logic [1:0] command;
  logic signed [CB-1:0] box_x;
  logic signed [CB-1:0] box_y;
  logic [CB-2:0] box_w;
  logic [CB-2:0] box_h;
  logic [7:0] track_id;
  modport source (output valid, command, box_x, box_y, box_w, box_h, track_id,
                  input ready);
  modport sink (input valid, command, box_x, box_y, box_w, box_h, track_id,
                output ready);
endinterface

interface giou_res_if;
  logic valid;
  logic ready;
  logic matched;
  logic [7:0] matched_id;
  logic [2:0] matched_slot;
  logic table_full;
  modport source (output valid, matched, matched_id, matched_slot, table_full,
                  input ready);
  modport sink (input valid, matched, matched_id, matched_slot, table_full,
                output ready);
endinterface

// ===== design/giou_cell.sv =====
// One track slot cell: holds a box and id, computes overlap with the
// detection as it passes, and forwards the running best down the chain.
// Depends on giou_pkg.
`timescale 1ns / 1ps
module giou_cell #(
  parameter int CB = 12,
  parameter int SW = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic signed [CB-1:0] ld_x,
  input  logic signed [CB-1:0] ld_y,
  input  logic [CB-2:0]        ld_w,
  input  logic [CB-2:0]        ld_h,
  input  logic [7:0]           ld_id,
  // detection box and running best arriving from the left neighbor
  input  logic                 in_vld,
  input  logic signed [CB-1:0] dx,
  input  logic signed [CB-1:0] dy,
  input  logic [CB-2:0]        dw,
  input  logic [CB-2:0]        dh,
  input  logic                 eligible,
  input  logic [3:0]           thr,
  input  logic                 in_found,
  input  logic [2*CB-1:0]      in_bi,
  input  logic [2*CB:0]        in_bu,
  input  logic [SW-1:0]        in_slot,
  input  logic [7:0]           in_id,
  input  logic [SW-1:0]        my_slot,
  output logic                 out_vld,
  output logic signed [CB-1:0] ox,
  output logic signed [CB-1:0] oy,
  output logic [CB-2:0]        ow,
  output logic [CB-2:0]        oh,
  output logic                 out_found,
  output logic [2*CB-1:0]      out_bi,
  output logic [2*CB:0]        out_bu,
  output logic [SW-1:0]        out_slot,
  output logic [7:0]           out_id
);
  import giou_pkg::*;
  localparam int IW = 2*CB;
  localparam int UW = 2*CB+1;

  logic signed [CB-1:0] tx, ty;
  logic [CB-2:0] tw, th;
  logic [7:0] tid;

  // stage A registers: overlap lengths and pass-through
  logic a_vld, a_el, a_found;
  logic signed [CB-1:0] a_x, a_y;
  logic [CB-2:0] a_w, a_h;
  logic [CB-1:0] a_ox, a_oy;
  logic [IW-1:0] a_bi;
  logic [UW-1:0] a_bu;
  logic [SW-1:0] a_slot;
  logic [7:0] a_id;

  logic signed [CB:0] lo_x, hi_x, lo_y, hi_y, ex_d, ex_t, ey_d, ey_t;
  logic [CB-1:0] ovx, ovy;

  // track storage
  always_ff @(posedge clk) begin
    if (load) begin
      tx <= ld_x; ty <= ld_y; tw <= ld_w; th <= ld_h; tid <= ld_id;
    end
  end

  // overlap along each axis
  always_comb begin
    ex_d = (CB+1)'(dx) + (CB+1)'($signed({2'b0, dw}));
    ex_t = (CB+1)'(tx) + (CB+1)'($signed({2'b0, tw}));
    ey_d = (CB+1)'(dy) + (CB+1)'($signed({2'b0, dh}));
    ey_t = (CB+1)'(ty) + (CB+1)'($signed({2'b0, th}));
    lo_x = (dx > tx) ? (CB+1)'(dx) : (CB+1)'(tx);
    lo_y = (dy > ty) ? (CB+1)'(dy) : (CB+1)'(ty);
    hi_x = (ex_d < ex_t) ? ex_d : ex_t;
    hi_y = (ey_d < ey_t) ? ey_d : ey_t;
    ovx = (hi_x > lo_x) ? CB'(hi_x - lo_x) : '0;
    ovy = (hi_y > lo_y) ? CB'(hi_y - lo_y) : '0;
  end

  always_ff @(posedge clk) begin
    a_el <= eligible;
    a_x <= dx; a_y <= dy; a_w <= dw; a_h <= dh;
    a_ox <= ovx; a_oy <= ovy;
    a_found <= in_found; a_bi <= in_bi; a_bu <= in_bu;
    a_slot <= in_slot; a_id <= in_id;
  end

  // stage B: areas, union; stage C: compares
  logic b_vld, b_el, b_found;
  logic signed [CB-1:0] b_x, b_y;
  logic [CB-2:0] b_w, b_h;
  logic [IW-1:0] b_i, b_bi;
  logic [UW-1:0] b_u, b_bu;
  logic [SW-1:0] b_slot;
  logic [7:0] b_id;
  logic [IW-1:0] inter, ad, at;

  always_comb begin
    inter = IW'(a_ox) * IW'(a_oy);
    ad = IW'(a_w) * IW'(a_h);
    at = IW'(tw) * IW'(th);
  end

  always_ff @(posedge clk) begin
    b_el <= a_el;
    b_x <= a_x; b_y <= a_y; b_w <= a_w; b_h <= a_h;
    b_i <= inter;
    b_u <= UW'(ad) + UW'(at) - UW'(inter);
    b_found <= a_found; b_bi <= a_bi; b_bu <= a_bu;
    b_slot <= a_slot; b_id <= a_id;
  end

  logic [IW+3:0] lhs_q;
  logic [UW+3:0] rhs_q;
  logic qual, beats;
  logic [IW+UW-1:0] p1, p2;

  always_comb begin
    lhs_q = (IW+4)'(b_i) * (IW+4)'(4'd10);
    rhs_q = (UW+4)'(b_u) * (UW+4)'(thr);
    qual = b_el && (b_u != '0) && ((UW+4)'(lhs_q) > rhs_q);
  end

  // stage C: threshold result and the two cross products
  logic c_vld, c_qual, c_found;
  logic signed [CB-1:0] c_x, c_y;
  logic [CB-2:0] c_w, c_h;
  logic [IW-1:0] c_i, c_bi;
  logic [UW-1:0] c_u, c_bu;
  logic [SW-1:0] c_slot;
  logic [7:0] c_id;

  always_ff @(posedge clk) begin
    c_qual <= qual;
    c_x <= b_x; c_y <= b_y; c_w <= b_w; c_h <= b_h;
    c_i <= b_i; c_u <= b_u;
    c_found <= b_found; c_bi <= b_bi; c_bu <= b_bu;
    c_slot <= b_slot; c_id <= b_id;
    p1 <= (IW+UW)'(b_i) * (IW+UW)'(b_bu);
    p2 <= (IW+UW)'(b_bi) * (IW+UW)'(b_u);
  end

  always_comb beats = c_qual && (!c_found || (p1 > p2));

  // valid bits of the four stages
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0; b_vld <= 1'b0; c_vld <= 1'b0; out_vld <= 1'b0;
    end else begin
      a_vld <= in_vld; b_vld <= a_vld; c_vld <= b_vld; out_vld <= c_vld;
    end
  end

  // hand over to the right neighbor
  always_ff @(posedge clk) begin
    ox <= c_x; oy <= c_y; ow <= c_w; oh <= c_h;
    out_found <= c_found | beats;
    out_bi <= beats ? c_i : c_bi;
    out_bu <= beats ? c_u : c_bu;
    out_slot <= beats ? my_slot : c_slot;
    out_id <= beats ? tid : c_id;
  end
endmodule

// ===== design/greedy_iou_track_assigner.sv =====
// Top level of the greedy IoU track assigner: command control, cell chain,
// result register. Depends on giou_pkg, giou_if, giou_cell.
//
//  channel  dir  payload
//  req      in   command, box_x, box_y, box_w, box_h, track_id
//  res      out  matched, matched_id, matched_slot, table_full
//  cfg      in   cfg_we, cfg_data (IoU threshold in tenths)
//
// A clear produces no result; an add result is valid the cycle after the request.
// A match walks the detection down the chain, four register stages per cell,
// and its result is registered when the detection leaves the last cell.
// One request is in flight at a time; req.ready is low while a match runs or a
// result waits, so the next request is taken only after the result is accepted.
// Synchronous reset empties the table, restores threshold 3.
`timescale 1ns / 1ps
module greedy_iou_track_assigner #(
  parameter int MAX_TRACKS = giou_pkg::MaxTracksDef,
  parameter int COORD_BITS = giou_pkg::CoordBitsDef
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [giou_pkg::ThrW-1:0] cfg_data,
  giou_req_if.sink req,
  giou_res_if.source res
);
  import giou_pkg::*;
  localparam int CB = COORD_BITS;
  localparam int N = MAX_TRACKS;
  localparam int SW = (N > 1) ? $clog2(N) : 1;
  localparam int CW = $clog2(N + 1);
  localparam int IW = 2*CB;
  localparam int UW = 2*CB+1;

  logic [ThrW-1:0] thr;
  logic [CW-1:0] count;
  logic [N-1:0] used;
  logic ovf;
  logic busy;
  logic out_valid;
  result_t out_r;

  logic acc;
  assign req.ready = !busy && !out_valid;
  assign acc = req.valid && req.ready;

  // chain wiring
  logic [N:0] c_vld, c_found;
  logic signed [CB-1:0] c_x [N+1];
  logic signed [CB-1:0] c_y [N+1];
  logic [CB-2:0] c_w [N+1];
  logic [CB-2:0] c_h [N+1];
  logic [IW-1:0] c_bi [N+1];
  logic [UW-1:0] c_bu [N+1];
  logic [SW-1:0] c_slot [N+1];
  logic [7:0] c_id [N+1];

  assign c_vld[0] = acc && (req.command == CMD_MATCH);
  assign c_x[0] = req.box_x;
  assign c_y[0] = req.box_y;
  assign c_w[0] = req.box_w;
  assign c_h[0] = req.box_h;
  assign c_found[0] = 1'b0;
  assign c_bi[0] = '0;
  assign c_bu[0] = '0;
  assign c_slot[0] = '0;
  assign c_id[0] = '0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic ld;
    assign ld = acc && (req.command == CMD_ADD) && (count == CW'(g));
    giou_cell #(.CB(CB), .SW(SW)) u_cell (
      .clk(clk), .rst(rst), .load(ld),
      .ld_x(req.box_x), .ld_y(req.box_y), .ld_w(req.box_w), .ld_h(req.box_h),
      .ld_id(req.track_id),
      .in_vld(c_vld[g]), .dx(c_x[g]), .dy(c_y[g]), .dw(c_w[g]), .dh(c_h[g]),
      .eligible((CW'(g) < count) && !used[g]), .thr(thr),
      .in_found(c_found[g]), .in_bi(c_bi[g]), .in_bu(c_bu[g]),
      .in_slot(c_slot[g]), .in_id(c_id[g]), .my_slot(SW'(g)),
      .out_vld(c_vld[g+1]), .ox(c_x[g+1]), .oy(c_y[g+1]), .ow(c_w[g+1]),
      .oh(c_h[g+1]), .out_found(c_found[g+1]), .out_bi(c_bi[g+1]),
      .out_bu(c_bu[g+1]), .out_slot(c_slot[g+1]), .out_id(c_id[g+1])
    );
  end

  // control state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= ThrReset;
      count <= '0;
      used <= '0;
      ovf <= 1'b0;
      busy <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) thr <= cfg_data;
      if (out_valid && res.ready) out_valid <= 1'b0;
      if (acc) begin
        unique case (req.command)
          CMD_CLEAR: begin
            count <= '0; used <= '0; ovf <= 1'b0;
          end
          CMD_ADD: begin
            out_valid <= 1'b1;
            if (count < CW'(N)) count <= count + 1'b1;
            else ovf <= 1'b1;
            out_r <= '{matched: 1'b0, matched_id: 8'd0, matched_slot: 3'd0,
                       table_full: ovf | (count >= CW'(N))};
          end
          CMD_MATCH: busy <= 1'b1;
          CMD_NOP: ;
        endcase
      end
      if (c_vld[N]) begin
        busy <= 1'b0;
        out_valid <= 1'b1;
        out_r <= '{matched: c_found[N],
                   matched_id: c_found[N] ? c_id[N] : 8'd0,
                   matched_slot: c_found[N] ? 3'(c_slot[N]) : 3'd0,
                   table_full: ovf};
        if (c_found[N]) used[c_slot[N]] <= 1'b1;
      end
    end
  end

  assign res.valid = out_valid;
  assign res.matched = out_r.matched;
  assign res.matched_id = out_r.matched_id;
  assign res.matched_slot = out_r.matched_slot;
  assign res.table_full = out_r.table_full;

  a_no_acc_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !req.ready) else $error("request taken during match");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(N)) else $error("track count overrun");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    c_vld[N] |-> busy) else $error("chain result without match");
endmodule

// ===== dv/tb.sv =====
// Testbench for greedy_iou_track_assigner: queued request driver, result monitor,
// and a scoreboard fed by a built-in IoU matching predictor.
// Depends on giou_pkg, giou_if and the design files.
`timescale 1ns / 1ps
module tb;
  import giou_pkg::*;

  localparam int NT = 8;
  localparam int CB = 12;

  typedef struct packed {
    logic [1:0]           command;
    logic signed [CB-1:0] box_x;
    logic signed [CB-1:0] box_y;
    logic [CB-2:0]        box_w;
    logic [CB-2:0]        box_h;
    logic [7:0]           track_id;
  } request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [ThrW-1:0] cfg_data = '0;

  giou_req_if #(.CB(CB)) req ();
  giou_res_if res ();

  greedy_iou_track_assigner #(.MAX_TRACKS(NT), .COORD_BITS(CB)) DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .req(req.sink), .res(res.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic signed [CB-1:0] trk_x [NT];
  logic signed [CB-1:0] trk_y [NT];
  logic [CB-2:0] trk_w [NT];
  logic [CB-2:0] trk_h [NT];
  logic [7:0] trk_id [NT];
  logic [NT-1:0] trk_used;
  int trk_count;
  logic trk_overflow;
  logic [ThrW-1:0] iou_thr;

  request_t pending_reqs[$];
  result_t  expected_results[$];
  int mismatches = 0;
  bit failed = 0;
  bit drive_idle = 0;    // no idling on either side
  bit sink_hold = 0;     // long receiver hold-off
  int hold_cycles = 0;

  function automatic longint span(longint a0, longint al, longint b0, longint bl);
    longint lo, hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = ((a0 + al) < (b0 + bl)) ? (a0 + al) : (b0 + bl);
    return (hi > lo) ? hi - lo : 0;
  endfunction

  // apply one accepted request to the predictor, queue its result if any
  task automatic predict_request(request_t r);
    result_t o;
    longint inter, uni, bi, bu, ad;
    bit found;
    int bs;
    o = '0;
    bi = 0; bu = 0; found = 0; bs = 0;
    if (r.command == CMD_CLEAR) begin
      trk_count = 0; trk_used = '0; trk_overflow = 1'b0;
    end else if (r.command == CMD_ADD) begin
      if (trk_count < NT) begin
        trk_x[trk_count] = r.box_x; trk_y[trk_count] = r.box_y;
        trk_w[trk_count] = r.box_w; trk_h[trk_count] = r.box_h;
        trk_id[trk_count] = r.track_id;
        trk_count++;
      end else trk_overflow = 1'b1;
      o.table_full = trk_overflow;
      expected_results = {expected_results, o};
    end else if (r.command == CMD_MATCH) begin
      ad = longint'(r.box_w) * longint'(r.box_h);
      for (int s = 0; s < trk_count; s++) begin
        if (trk_used[s]) continue;
        inter = span(r.box_x, r.box_w, trk_x[s], trk_w[s]) *
                span(r.box_y, r.box_h, trk_y[s], trk_h[s]);
        uni = ad + longint'(trk_w[s]) * longint'(trk_h[s]) - inter;
        if (uni == 0) continue;
        if (!(10 * inter > longint'(iou_thr) * uni)) continue;
        if (!found || inter * bu > bi * uni) begin
          found = 1; bi = inter; bu = uni; bs = s;
        end
      end
      if (found) begin
        trk_used[bs] = 1'b1;
        o.matched = 1'b1; o.matched_id = trk_id[bs]; o.matched_slot = bs[2:0];
      end
      o.table_full = trk_overflow;
      expected_results = {expected_results, o};
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req.ready) begin
      if (req.valid) predict_request({req.command, req.box_x, req.box_y,
                                      req.box_w, req.box_h, req.track_id});
      if (pending_reqs.size() > 0 && (drive_idle || $urandom_range(99) >= 17)) begin
        request_t r;
        r = pending_reqs.pop_front();
        req.valid <= 1'b1;
        req.command <= r.command; req.box_x <= r.box_x; req.box_y <= r.box_y;
        req.box_w <= r.box_w; req.box_h <= r.box_h; req.track_id <= r.track_id;
      end else req.valid <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        result_t got, want;
        got = {res.matched, res.matched_id, res.matched_slot, res.table_full};
        if (expected_results.size() == 0) begin
          failed = 1;
          if (mismatches < 10) $display("unexpected result %h", got);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            failed = 1;
            if (mismatches < 10)
              $display({"mismatch: expected m=%0d id=%0d slot=%0d full=%0d, ",
                        "got m=%0d id=%0d slot=%0d full=%0d"},
                       want.matched, want.matched_id, want.matched_slot,
                       want.table_full, got.matched, got.matched_id,
                       got.matched_slot, got.table_full);
            mismatches++;
          end
        end
      end
      res.ready <= !sink_hold && (drive_idle || $urandom_range(99) >= 17);
    end
  end

  // receiver hold-off counter
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      sink_hold <= (hold_cycles > 1);
    end
  end

  function automatic request_t rand_box(logic [1:0] c, bit near, request_t ref_r);
    request_t r;
    r.command = c;
    r.track_id = 8'($urandom);
    if (near) begin
      r.box_x = ref_r.box_x + 12'($signed($urandom_range(8)) - 4);
      r.box_y = ref_r.box_y + 12'($signed($urandom_range(8)) - 4);
      r.box_w = ref_r.box_w + 11'($urandom_range(6));
      r.box_h = ref_r.box_h + 11'($urandom_range(6));
    end else if ($urandom_range(9) == 0) begin
      r.box_x = 12'($urandom); r.box_y = 12'($urandom);
      r.box_w = 11'($urandom); r.box_h = 11'($urandom);
    end else begin
      r.box_x = 12'($urandom_range(200)); r.box_y = 12'($urandom_range(200));
      r.box_w = 11'($urandom_range(60)); r.box_h = 11'($urandom_range(60));
    end
    return r;
  endfunction

  task automatic push(logic [1:0] c, int x, int y, int w, int h, int id);
    request_t r;
    r.command = c; r.box_x = 12'(x); r.box_y = 12'(y);
    r.box_w = 11'(w); r.box_h = 11'(h); r.track_id = 8'(id);
    pending_reqs = {pending_reqs, r};
  endtask

  // wait until idle, then let the match pipeline drain
  task automatic settle();
    wait (pending_reqs.size() == 0 && !req.valid);
    wait (expected_results.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_thr(int v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_data <= 4'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    iou_thr = 4'(v);
  endtask

  initial begin
    request_t t, d;
    int frames;
    trk_count = 0; trk_used = '0; trk_overflow = 1'b0; iou_thr = ThrReset;
    res.ready = 1'b0; req.valid = 1'b0; req.command = '0; req.box_x = '0;
    req.box_y = '0; req.box_w = '0; req.box_h = '0; req.track_id = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, ties, zero union, overflow, ignored command
    push(CMD_CLEAR, 0, 0, 0, 0, 0);
    push(CMD_MATCH, 0, 0, 10, 10, 0);              // empty table
    push(CMD_ADD, -2048, -2048, 2047, 2047, 255);
    push(CMD_ADD, 2047, 2047, 0, 0, 0);            // zero area
    push(CMD_ADD, 10, 10, 20, 20, 17);
    push(CMD_ADD, 10, 10, 20, 20, 18);             // tie with slot 2
    push(CMD_MATCH, 2047, 2047, 0, 0, 0);          // zero union
    push(CMD_MATCH, 10, 10, 20, 20, 0);            // tie, earliest slot
    push(CMD_MATCH, 10, 10, 20, 20, 0);
    push(CMD_MATCH, 11, 11, 20, 20, 0);            // used tracks skipped
    push(CMD_ADD, 0, 0, 5, 5, 1);
    push(CMD_ADD, 0, 0, 5, 5, 2);
    push(CMD_ADD, 0, 0, 5, 5, 3);
    push(CMD_ADD, 0, 0, 5, 5, 4);
    push(CMD_ADD, 0, 0, 5, 5, 5);                  // overflow
    push(CMD_NOP, 1, 1, 1, 1, 1);                  // ignored command
    push(CMD_MATCH, -2048, -2048, 2047, 2047, 0);
    push(CMD_MATCH, 0, 0, 5, 5, 0);
    push(CMD_CLEAR, 0, 0, 0, 0, 0);
    push(CMD_MATCH, 0, 0, 5, 5, 0);
    settle();

    // random frames over several thresholds
    frames = 0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_thr(0);
        1: write_thr(10);
        2: write_thr(15);
        3: write_thr(5);
        default: write_thr($urandom_range(15));
      endcase
      drive_idle = (ph == 3);
      for (int f = 0; f < 22; f++) begin
        request_t tracks[$];
        int n;
        int m;
        push(CMD_CLEAR, 0, 0, 0, 0, 0);
        n = $urandom_range(10);
        for (int k = 0; k < n; k++) begin
          t = rand_box(CMD_ADD, 0, t);
          tracks = {tracks, t};
          pending_reqs = {pending_reqs, t};
        end
        m = $urandom_range(9);
        for (int k = 0; k < m; k++) begin
          if (tracks.size() > 0 && $urandom_range(4) != 0)
            d = rand_box(CMD_MATCH, 1, tracks[$urandom_range(tracks.size() - 1)]);
          else
            d = rand_box(CMD_MATCH, 0, t);
          pending_reqs = {pending_reqs, d};
        end
        if ($urandom_range(9) == 0) begin
          d = rand_box($urandom_range(1) ? CMD_NOP : CMD_ADD, 0, t);
          pending_reqs = {pending_reqs, d};
        end
        if (ph == 2 && f == 5) begin
          sink_hold <= 1'b1;
          hold_cycles <= 300;
        end
      end
      settle();
    end

    wait (expected_results.size() == 0);
    repeat (50) @(posedge clk);
    if (!failed) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end
endmodule

// ===== files.f =====
design/giou_pkg.sv
design/giou_if.sv
design/giou_cell.sv
design/greedy_iou_track_assigner.sv
dv/tb.sv
